// File: design/mneg_pkg.sv
`default_nettype none
package mneg_pkg;

    // field widths
    localparam int CMD_W    = 4;
    localparam int TRACK_W  = 3;
    localparam int NOTE_W   = 7;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 8;
    localparam int DATA2_W  = 8;

    // parameter defaults
    localparam int TRACKS_DEF          = 8;
    localparam int NOTES_PER_TRACK_DEF = 8;

    // most messages one event may produce
    localparam int OUT_LIMIT = 24;

    // event queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VOLUME = 2'd2;

    // event commands
    localparam logic [CMD_W-1:0] CMD_START    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_STOP     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RETRIG   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_VELOCITY = 4'd4;
    localparam logic [CMD_W-1:0] CMD_VOLUME   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CHORD    = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CC       = 4'd7;
    localparam logic [CMD_W-1:0] CMD_PROGRAM  = 4'd8;

    // MIDI status high nibbles
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CTRL     = 4'hB;
    localparam logic [3:0] ST_PROGRAM  = 4'hC;

    localparam logic [NOTE_W-1:0] CC_VOLUME = 7'd7;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [TRACK_W-1:0] track;
        logic [NOTE_W-1:0]  note;
        logic               mute;
        logic [VALUE_W-1:0] value;
    } mneg_item_t;

endpackage
`default_nettype wire

// File: design/mneg_front.sv
`default_nettype none
module mneg_front
    import mneg_pkg::*;
#(
    parameter int TRACKS = TRACKS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [CMD_W-1:0]   command,
    input  wire logic [TRACK_W-1:0] track,
    input  wire logic [NOTE_W-1:0]  note,
    input  wire logic               mute,
    input  wire logic [VALUE_W-1:0] value,
    output logic                    q_valid,
    output mneg_item_t              q_item,
    input  wire logic               q_pop
);

    mneg_item_t        q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;
    logic              accept;
    logic              keep;
    logic              push;

    // events for absent tracks or unknown commands cause nothing: drop them here
    assign keep = (32'(track) < TRACKS) && (command <= CMD_PROGRAM);

    assign in_stall = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign push     = accept && keep;
    assign q_valid  = (fill_reg != '0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !q_pop)
        begin
            fill_next = fill_reg + (QPTR_W + 1)'(1);
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{command: command, track: track, note: note,
                                   mute: mute, value: value};
        end
    end

endmodule
`default_nettype wire

// File: design/mneg_engine.sv
`default_nettype none
module mneg_engine
    import mneg_pkg::*;
#(
    parameter int TRACKS          = TRACKS_DEF,
    parameter int NOTES_PER_TRACK = NOTES_PER_TRACK_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  q_valid,
    input  wire mneg_item_t            q_item,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [NOTE_W-1:0]          data_first,
    output logic [DATA2_W-1:0]         data_second,
    output logic                       has_second,
    output logic                       last
);

    localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int EXT_W  = (TRK_W > TRACK_W) ? TRK_W : TRACK_W;
    localparam int IDX_W  = $clog2(NOTES_PER_TRACK);
    localparam int CNT_W  = $clog2(NOTES_PER_TRACK + 1);
    localparam int DEPTH  = TRACKS * NOTES_PER_TRACK;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int EC_W   = $clog2(OUT_LIMIT + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ONE    = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_SEARCH = 3'd3;
    localparam logic [2:0] S_CHORD  = 3'd4;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ON   = 2'd1;
    localparam logic [1:0] PH_OFF  = 2'd2;
    localparam logic [1:0] PH_RT   = 2'd3;

    // configuration
    logic [3:0] midi_channel_reg;
    logic [7:0] note_length_reg;
    logic [7:0] start_volume_reg;

    // per-track state
    logic [CNT_W-1:0]  note_count_reg [TRACKS];
    logic [CNT_W-1:0]  note_count_next [TRACKS];
    logic [NOTE_W-1:0] root_reg [TRACKS];
    logic [NOTE_W-1:0] root_next [TRACKS];
    logic              muted_reg [TRACKS];
    logic              muted_next [TRACKS];
    logic              first_reg [TRACKS];
    logic              first_next [TRACKS];

    // shared state
    logic [8:0] ticks_reg, ticks_next;
    logic       retrig_reg, retrig_next;
    logic [7:0] period_reg, period_next;
    logic [7:0] vel_reg, vel_next;

    // note store
    logic [NOTE_W-1:0] mem [DEPTH];
    logic [NOTE_W-1:0] rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [NOTE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    // sequencer
    logic [2:0]        state_reg, state_next;
    logic [TRK_W-1:0]  track_reg, track_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              sub_reg, sub_next;
    logic [1:0]        phase_reg, phase_next;
    logic [1:0]        phase2_reg, phase2_next;
    logic [CNT_W-1:0]  walk_n_reg, walk_n_next;
    logic [EC_W-1:0]   ecnt_reg, ecnt_next;
    logic [3:0]        msg_code_reg, msg_code_next;
    logic [NOTE_W-1:0] msg_d1_reg, msg_d1_next;
    logic [7:0]        msg_d2_reg, msg_d2_next;
    logic              msg_has2_reg, msg_has2_next;
    logic [NOTE_W-1:0] tone0_reg, tone0_next;
    logic [NOTE_W-1:0] tone1_reg, tone1_next;
    logic              found0_reg, found0_next;
    logic              found1_reg, found1_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [3:0]        out_code_reg;
    logic [3:0]        out_chan_reg;
    logic [NOTE_W-1:0] out_d1_reg;
    logic [7:0]        out_d2_reg;
    logic              out_has2_reg;
    logic              out_last_reg;

    logic              emit;
    logic [3:0]        e_code;
    logic [NOTE_W-1:0] e_d1;
    logic [7:0]        e_d2;
    logic              e_has2;
    logic              e_last;
    logic              out_free;

    logic [EXT_W-1:0]  head_ext;
    logic [TRK_W-1:0]  head_t;
    logic [TRK_W-1:0]  sel_t;
    logic [CNT_W-1:0]  cur_cnt;
    logic [NOTE_W-1:0] cur_root;
    logic              cur_muted;
    logic              cur_first;
    logic              room;
    logic              end_hit;
    logic              end_act;
    logic [1:0]        end_ph;
    logic              walk_on;
    logic              phase_end;
    logic              all_end;
    logic              cap;
    logic              idx_last;
    logic              em0;
    logic              em1;

    assign head_ext  = EXT_W'(q_item.track);
    assign head_t    = head_ext[TRK_W-1:0];
    assign sel_t     = (state_reg == S_IDLE) ? head_t : track_reg;
    assign cur_cnt   = note_count_reg[sel_t];
    assign cur_root  = root_reg[sel_t];
    assign cur_muted = muted_reg[sel_t];
    assign cur_first = first_reg[sel_t];
    assign room      = (cur_cnt < CNT_W'(NOTES_PER_TRACK));

    assign end_hit = (ticks_reg == 9'd1);
    assign end_act = end_hit && (retrig_reg || !q_item.mute);
    assign end_ph  = retrig_reg ? PH_RT : PH_OFF;

    assign idx_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == walk_n_reg);
    assign walk_on   = (phase_reg == PH_ON) || ((phase_reg == PH_RT) && sub_reg);
    assign phase_end = idx_last && ((phase_reg != PH_RT) || sub_reg);
    assign all_end   = phase_end && (phase2_reg == PH_NONE);
    assign cap       = (ecnt_reg == EC_W'(OUT_LIMIT - 1));

    // chord tones: second tone also counts as sounded if the first was just inserted
    assign em0 = !((tone0_reg == cur_root) || found0_reg);
    assign em1 = !((tone1_reg == cur_root) || found1_reg ||
                   (em0 && (tone0_reg == tone1_reg) &&
                    (walk_n_reg < CNT_W'(NOTES_PER_TRACK))));

    assign out_free  = !out_valid_reg || !out_stall;
    assign mem_waddr = ADDR_W'(sel_t) * ADDR_W'(NOTES_PER_TRACK)
                     + ADDR_W'(cur_cnt[IDX_W-1:0]);
    assign mem_raddr = ADDR_W'(track_next) * ADDR_W'(NOTES_PER_TRACK)
                     + ADDR_W'(idx_next);

    always_comb
    begin
        state_next      = state_reg;
        track_next      = track_reg;
        idx_next        = idx_reg;
        sub_next        = sub_reg;
        phase_next      = phase_reg;
        phase2_next     = phase2_reg;
        walk_n_next     = walk_n_reg;
        ecnt_next       = ecnt_reg;
        msg_code_next   = msg_code_reg;
        msg_d1_next     = msg_d1_reg;
        msg_d2_next     = msg_d2_reg;
        msg_has2_next   = msg_has2_reg;
        tone0_next      = tone0_reg;
        tone1_next      = tone1_reg;
        found0_next     = found0_reg;
        found1_next     = found1_reg;
        ticks_next      = ticks_reg;
        retrig_next     = retrig_reg;
        period_next     = period_reg;
        vel_next        = vel_reg;
        note_count_next = note_count_reg;
        root_next       = root_reg;
        muted_next      = muted_reg;
        first_next      = first_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_wdata       = q_item.note;
        emit            = 1'b0;
        e_code          = ST_NOTE_ON;
        e_d1            = rdata_reg;
        e_d2            = vel_reg;
        e_has2          = 1'b1;
        e_last          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    track_next  = head_t;
                    idx_next    = '0;
                    sub_next    = 1'b0;
                    ecnt_next   = '0;
                    walk_n_next = cur_cnt;
                    case (q_item.command)
                        CMD_START:
                        begin
                            root_next[head_t] = q_item.note;
                            if (q_item.mute)
                            begin
                                muted_next[head_t] = 1'b1;
                            end
                            else
                            begin
                                if (room)
                                begin
                                    mem_we                  = 1'b1;
                                    note_count_next[head_t] = cur_cnt + CNT_W'(1);
                                end
                                first_next[head_t] = 1'b1;
                                muted_next[head_t] = 1'b0;
                                ticks_next         = {1'b0, note_length_reg};
                                vel_next           = {1'b0, start_volume_reg[7:1]};
                                retrig_next        = 1'b0;
                                msg_code_next      = ST_CTRL;
                                msg_d1_next        = CC_VOLUME;
                                msg_d2_next        = {1'b0, start_volume_reg[7:1]};
                                msg_has2_next      = 1'b1;
                                state_next         = S_ONE;
                            end
                        end
                        CMD_STOP:
                        begin
                            if (!cur_muted)
                            begin
                                note_count_next[head_t] = '0;
                                if (cur_cnt != '0)
                                begin
                                    phase_next  = PH_OFF;
                                    phase2_next = PH_NONE;
                                    state_next  = S_WALK;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (q_item.mute && !cur_muted)
                            begin
                                // mute raised: silence the track, nothing else this tick
                                muted_next[head_t]      = 1'b1;
                                note_count_next[head_t] = '0;
                                if (cur_cnt != '0)
                                begin
                                    phase_next  = PH_OFF;
                                    phase2_next = PH_NONE;
                                    state_next  = S_WALK;
                                end
                            end
                            else
                            begin
                                muted_next[head_t] = q_item.mute;
                                first_next[head_t] = 1'b0;
                                if (ticks_reg != '0)
                                begin
                                    ticks_next = (end_hit && retrig_reg) ?
                                                 {1'b0, period_reg} : ticks_reg - 9'd1;
                                end
                                if (end_hit && !retrig_reg && !q_item.mute)
                                begin
                                    note_count_next[head_t] = '0;
                                end
                                if (cur_cnt != '0)
                                begin
                                    if (cur_first)
                                    begin
                                        phase_next  = PH_ON;
                                        phase2_next = end_act ? end_ph : PH_NONE;
                                        state_next  = S_WALK;
                                    end
                                    else if (end_act)
                                    begin
                                        phase_next  = end_ph;
                                        phase2_next = PH_NONE;
                                        state_next  = S_WALK;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            if (!cur_muted)
                            begin
                                case (q_item.command)
                                    CMD_RETRIG:
                                    begin
                                        if (q_item.value[7:0] != '0)
                                        begin
                                            retrig_next = 1'b1;
                                            period_next = q_item.value[7:0];
                                            ticks_next  = {1'b0, q_item.value[7:0]};
                                        end
                                        else
                                        begin
                                            retrig_next = 1'b0;
                                        end
                                    end
                                    CMD_VELOCITY:
                                    begin
                                        vel_next = q_item.value[8:1];
                                    end
                                    CMD_VOLUME:
                                    begin
                                        msg_code_next = ST_CTRL;
                                        msg_d1_next   = CC_VOLUME;
                                        msg_d2_next   = q_item.value[8:1];
                                        msg_has2_next = 1'b1;
                                        state_next    = S_ONE;
                                    end
                                    CMD_CHORD:
                                    begin
                                        tone0_next  = cur_root + q_item.value[6:0];
                                        tone1_next  = cur_root + q_item.value[14:8];
                                        found0_next = 1'b0;
                                        found1_next = 1'b0;
                                        state_next  = (cur_cnt != '0) ? S_SEARCH : S_CHORD;
                                    end
                                    CMD_CC:
                                    begin
                                        msg_code_next = ST_CTRL;
                                        msg_d1_next   = q_item.value[14:8];
                                        msg_d2_next   = {1'b0, q_item.value[6:0]};
                                        msg_has2_next = 1'b1;
                                        state_next    = S_ONE;
                                    end
                                    CMD_PROGRAM:
                                    begin
                                        msg_code_next = ST_PROGRAM;
                                        msg_d1_next   = q_item.value[6:0];
                                        msg_d2_next   = 8'hFF;
                                        msg_has2_next = 1'b0;
                                        state_next    = S_ONE;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
            S_ONE:
            begin
                e_code = msg_code_reg;
                e_d1   = msg_d1_reg;
                e_d2   = msg_d2_reg;
                e_has2 = msg_has2_reg;
                e_last = 1'b1;
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                e_code = walk_on ? ST_NOTE_ON : ST_NOTE_OFF;
                e_d1   = rdata_reg;
                e_d2   = walk_on ? vel_reg : 8'd0;
                e_last = all_end || cap;
                if (out_free)
                begin
                    emit      = 1'b1;
                    ecnt_next = ecnt_reg + EC_W'(1);
                    if (all_end || cap)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (phase_end)
                    begin
                        phase_next  = phase2_reg;
                        phase2_next = PH_NONE;
                        idx_next    = '0;
                        sub_next    = 1'b0;
                    end
                    else if ((phase_reg == PH_RT) && !sub_reg)
                    begin
                        sub_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                        sub_next = 1'b0;
                    end
                end
            end
            S_SEARCH:
            begin
                found0_next = found0_reg || (rdata_reg == tone0_reg);
                found1_next = found1_reg || (rdata_reg == tone1_reg);
                if (idx_last)
                begin
                    state_next = S_CHORD;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_CHORD:
            begin
                e_code = ST_NOTE_ON;
                e_d2   = vel_reg;
                if (!sub_reg)
                begin
                    e_d1      = tone0_reg;
                    e_last    = !em1;
                    mem_wdata = tone0_reg;
                    if (!em0)
                    begin
                        if (em1)
                        begin
                            sub_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else if (out_free)
                    begin
                        emit = 1'b1;
                        if (room)
                        begin
                            mem_we                     = 1'b1;
                            note_count_next[track_reg] = cur_cnt + CNT_W'(1);
                        end
                        if (em1)
                        begin
                            sub_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    e_d1      = tone1_reg;
                    e_last    = 1'b1;
                    mem_wdata = tone1_reg;
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (room)
                        begin
                            mem_we                     = 1'b1;
                            note_count_next[track_reg] = cur_cnt + CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            midi_channel_reg <= 4'd0;
            note_length_reg  <= 8'd0;
            start_volume_reg <= 8'd255;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIDI_CHANNEL: midi_channel_reg <= cfg_data[3:0];
                CFG_NOTE_LENGTH:  note_length_reg  <= cfg_data;
                CFG_START_VOLUME: start_volume_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ticks_reg     <= '0;
            retrig_reg    <= 1'b0;
            period_reg    <= '0;
            vel_reg       <= 8'd127;
            for (int i = 0; i < TRACKS; i++)
            begin
                note_count_reg[i] <= '0;
                root_reg[i]       <= '0;
                muted_reg[i]      <= 1'b0;
                first_reg[i]      <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            ticks_reg      <= ticks_next;
            retrig_reg     <= retrig_next;
            period_reg     <= period_next;
            vel_reg        <= vel_next;
            note_count_reg <= note_count_next;
            root_reg       <= root_next;
            muted_reg      <= muted_next;
            first_reg      <= first_next;
        end
    end

    // working registers of the current event
    always_ff @(posedge clk)
    begin
        track_reg    <= track_next;
        idx_reg      <= idx_next;
        sub_reg      <= sub_next;
        phase_reg    <= phase_next;
        phase2_reg   <= phase2_next;
        walk_n_reg   <= walk_n_next;
        ecnt_reg     <= ecnt_next;
        msg_code_reg <= msg_code_next;
        msg_d1_reg   <= msg_d1_next;
        msg_d2_reg   <= msg_d2_next;
        msg_has2_reg <= msg_has2_next;
        tone0_reg    <= tone0_next;
        tone1_reg    <= tone1_next;
        found0_reg   <= found0_next;
        found1_reg   <= found1_next;
        if (emit)
        begin
            out_code_reg <= e_code;
            out_chan_reg <= midi_channel_reg;
            out_d1_reg   <= e_d1;
            out_d2_reg   <= e_d2;
            out_has2_reg <= e_has2;
            out_last_reg <= e_last;
        end
    end

    // note store: one write port, registered read at the next index
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign status      = {out_code_reg, out_chan_reg};
    assign data_first  = out_d1_reg;
    assign data_second = out_d2_reg;
    assign has_second  = out_has2_reg;
    assign last        = out_last_reg;

endmodule
`default_nettype wire

// File: design/midi_note_event_generator_top.sv
// MIDI note event generator: tracker events in, MIDI messages out.
//
// Input channel (in_valid / in_stall): one event per transaction. A front
// stage filters events for absent tracks or unknown commands and queues the
// rest in a two-entry queue; in_stall rises only while that queue is full.
// Output channel (out_valid / out_stall): one MIDI message per transaction,
// last marks the final message of an event. Messages wait in an output
// register while out_stall is high; the back end then holds its place.
// Config channel (cfg_valid / cfg_ready): always ready; the user must see
// that it is written only while idle, which the block does not enforce.
//
// An event passes the front queue, then the back sequencer's idle state,
// where it is set up, before its first message enters the output register.
// The sequencer takes no new event until it is done with the last one. It
// sends the messages one by one; a chord first searches the track's note
// list note by note. The note store read port sets this pace.
// Reset: all tracks empty and unmuted, velocity 127, start volume 255,
// channel 0; the note store needs no clearing pass.
`default_nettype none
module midi_note_event_generator_top
    import mneg_pkg::*;
#(
    parameter int TRACKS          = TRACKS_DEF,
    parameter int NOTES_PER_TRACK = NOTES_PER_TRACK_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // event channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [TRACK_W-1:0]    track,
    input  wire logic [NOTE_W-1:0]     note,
    input  wire logic                  mute,
    input  wire logic [VALUE_W-1:0]    value,
    // message channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [NOTE_W-1:0]          data_first,
    output logic [DATA2_W-1:0]         data_second,
    output logic                       has_second,
    output logic                       last,
    // configuration channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic       q_valid;
    mneg_item_t q_item;
    logic       q_pop;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    mneg_front #(
        .TRACKS (TRACKS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .track    (track),
        .note     (note),
        .mute     (mute),
        .value    (value),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    mneg_engine #(
        .TRACKS          (TRACKS),
        .NOTES_PER_TRACK (NOTES_PER_TRACK)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .data_first  (data_first),
        .data_second (data_second),
        .has_second  (has_second),
        .last        (last)
    );

endmodule
`default_nettype wire

// File: tb/mneg_scoreboard_pkg.sv
`timescale 1ns / 1ps
package mneg_scoreboard_pkg;
    import mneg_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NOTE_W-1:0]   data_first;
        logic [DATA2_W-1:0]  data_second;
        logic                has_second;
        logic                last;
    } midi_msg_t;

    class midi_scoreboard;
        // per track note lists and flags
        logic [NOTE_W-1:0] note_list [TRACKS_DEF][NOTES_PER_TRACK_DEF];
        int unsigned       note_cnt [TRACKS_DEF];
        logic [NOTE_W-1:0] root [TRACKS_DEF];
        bit                muted [TRACKS_DEF];
        bit                pending_on [TRACKS_DEF];
        // shared playback state
        int unsigned       countdown;
        bit                retrig_en;
        logic [7:0]        retrig_len;
        logic [7:0]        velocity;
        // register copies
        logic [3:0]        channel;
        logic [7:0]        hold_ticks;
        logic [7:0]        attack_volume;

        midi_msg_t         expected_msgs [$];
        midi_msg_t         burst [$];
        int                errors;

        function new();
            for (int i = 0; i < TRACKS_DEF; i++) begin
                note_cnt[i]   = 0;
                root[i]       = '0;
                muted[i]      = 1'b0;
                pending_on[i] = 1'b0;
            end
            countdown     = 0;
            retrig_en     = 1'b0;
            retrig_len    = '0;
            velocity      = 8'd127;
            channel       = '0;
            hold_ticks    = '0;
            attack_volume = 8'd255;
            errors        = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIDI_CHANNEL: channel       = data[3:0];
                CFG_NOTE_LENGTH:  hold_ticks    = data;
                CFG_START_VOLUME: attack_volume = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_msgs.size();
        endfunction

        function void emit(logic [3:0] base, logic [NOTE_W-1:0] d1, logic [7:0] d2, bit has2);
            midi_msg_t m;
            if (burst.size() >= OUT_LIMIT)
                return;
            m.status      = {base, 4'h0} + {4'h0, channel};
            m.data_first  = d1;
            m.data_second = d2;
            m.has_second  = has2;
            m.last        = 1'b0;
            burst.push_back(m);
        endfunction

        function void note_msg(bit on, logic [NOTE_W-1:0] n);
            emit(on ? ST_NOTE_ON : ST_NOTE_OFF, n, on ? velocity : 8'h00, 1'b1);
        endfunction

        function void insert(int t, logic [NOTE_W-1:0] n);
            if (note_cnt[t] < NOTES_PER_TRACK_DEF) begin
                note_list[t][note_cnt[t]] = n;
                note_cnt[t]++;
            end
        endfunction

        function void silence(int t);
            if (muted[t])
                return;
            for (int i = 0; i < note_cnt[t]; i++)
                note_msg(1'b0, note_list[t][i]);
            note_cnt[t] = 0;
        endfunction

        // Accepted event: update the model and queue the messages it causes.
        function void note_event(mneg_item_t it);
            int                t;
            int unsigned       n;
            logic [7:0]        step;
            logic [NOTE_W-1:0] tone;
            bit                sounded;
            t = it.track;
            burst.delete();
            if (t < TRACKS_DEF) begin
                n = note_cnt[t];
                case (it.command)
                    CMD_START: begin
                        root[t] = it.note;
                        if (it.mute)
                            muted[t] = 1'b1;
                        else begin
                            insert(t, it.note);
                            pending_on[t] = 1'b1;
                            muted[t]      = 1'b0;
                            countdown     = hold_ticks;
                            velocity      = attack_volume >> 1;
                            emit(ST_CTRL, CC_VOLUME, velocity, 1'b1);
                            retrig_en     = 1'b0;
                        end
                    end
                    CMD_STOP: silence(t);
                    CMD_TICK: begin
                        if (it.mute && !muted[t]) begin
                            silence(t);
                            muted[t] = 1'b1;
                        end else begin
                            if (!it.mute)
                                muted[t] = 1'b0;
                            if (pending_on[t]) begin
                                for (int i = 0; i < n; i++)
                                    note_msg(1'b1, note_list[t][i]);
                                pending_on[t] = 1'b0;
                            end
                            if (countdown > 0) begin
                                countdown--;
                                if (countdown == 0) begin
                                    if (!retrig_en)
                                        silence(t);
                                    else begin
                                        countdown = retrig_len;
                                        for (int i = 0; i < n; i++) begin
                                            note_msg(1'b0, note_list[t][i]);
                                            note_msg(1'b1, note_list[t][i]);
                                        end
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        if (it.command <= CMD_PROGRAM && !muted[t]) begin
                            case (it.command)
                                CMD_RETRIG: begin
                                    if (it.value[7:0] != 0) begin
                                        retrig_en  = 1'b1;
                                        retrig_len = it.value[7:0];
                                        countdown  = it.value[7:0];
                                    end else
                                        retrig_en = 1'b0;
                                end
                                CMD_VELOCITY: velocity = it.value[8:1];
                                CMD_VOLUME:   emit(ST_CTRL, CC_VOLUME, it.value[8:1], 1'b1);
                                CMD_CHORD: begin
                                    for (int k = 0; k < 2; k++) begin
                                        step    = (k == 0) ? it.value[7:0] : it.value[15:8];
                                        tone    = NOTE_W'(root[t] + step);
                                        sounded = (tone == root[t]);
                                        for (int i = 0; i < note_cnt[t]; i++)
                                            if (note_list[t][i] == tone)
                                                sounded = 1'b1;
                                        if (!sounded) begin
                                            note_msg(1'b1, tone);
                                            insert(t, tone);
                                        end
                                    end
                                end
                                CMD_CC: emit(ST_CTRL, it.value[14:8], {1'b0, it.value[6:0]}, 1'b1);
                                default: emit(ST_PROGRAM, it.value[6:0], 8'hFF, 1'b0);
                            endcase
                        end
                    end
                endcase
            end
            if (burst.size() > 0)
                burst[burst.size()-1].last = 1'b1;
            foreach (burst[i])
                expected_msgs.push_back(burst[i]);
        endfunction

        function void check_message(midi_msg_t got);
            midi_msg_t want;
            if (expected_msgs.size() == 0) begin
                $display("%0t: unexpected message, expected none got %h", $time, got);
                errors++;
                return;
            end
            want = expected_msgs.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %h got %h", $time, want.status, got.status);
                errors++;
            end
            if (got.data_first !== want.data_first) begin
                $display("%0t: data_first expected %h got %h", $time,
                         want.data_first, got.data_first);
                errors++;
            end
            if (got.data_second !== want.data_second) begin
                $display("%0t: data_second expected %h got %h", $time,
                         want.data_second, got.data_second);
                errors++;
            end
            if (got.has_second !== want.has_second) begin
                $display("%0t: has_second expected %b got %b", $time,
                         want.has_second, got.has_second);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b got %b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: tb/tb_midi_note_event_generator_top.sv
`timescale 1ns / 1ps
module tb_midi_note_event_generator_top;
    import mneg_pkg::*;
    import mneg_scoreboard_pkg::*;

    // cycles to let the back end finish after the last expected message
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 72;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      command = '0;
    logic [TRACK_W-1:0]    track = '0;
    logic [NOTE_W-1:0]     note = '0;
    logic                  mute = 1'b0;
    logic [VALUE_W-1:0]    value = '0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [NOTE_W-1:0]     data_first;
    logic [DATA2_W-1:0]    data_second;
    logic                  has_second;
    logic                  last;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // when set, neither side inserts idle cycles
    bit                    no_idle = 1'b0;

    midi_scoreboard        sb = new();

    midi_note_event_generator_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .track       (track),
        .note        (note),
        .mute        (mute),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .data_first  (data_first),
        .data_second (data_second),
        .has_second  (has_second),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One event transaction. Valid only drops when a gap follows, so a
    // back-to-back item never sees valid lowered and raised in one step.
    // The edge that accepts is the one where stall was low just before it.
    task automatic send_event(input mneg_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= it.command;
        track    <= it.track;
        note     <= it.note;
        mute     <= it.mute;
        value    <= it.value;
        do @(posedge clk); while (in_stall);
        sb.note_event(it);
    endtask

    task automatic ev(input logic [CMD_W-1:0] cmd, input int trk, input int nt,
                      input bit m, input logic [VALUE_W-1:0] v);
        mneg_item_t it;
        it.command = cmd;
        it.track   = TRACK_W'(trk);
        it.note    = NOTE_W'(nt);
        it.mute    = m;
        it.value   = v;
        send_event(it);
    endtask

    // Hold the sender until every expected message has come out.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Drain, then give events that produce nothing time to finish.
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three registers; valid stays high across the burst.
    task automatic write_registers(input logic [3:0] chan, input logic [7:0] len,
                                   input logic [7:0] vol);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] data [3];
        idx  = '{CFG_MIDI_CHANNEL, CFG_NOTE_LENGTH, CFG_START_VOLUME};
        data = '{CFG_DATA_W'(chan), len, vol};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= data[i];
            do @(posedge clk); while (!cfg_ready);
            sb.set_register(idx[i], data[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Message sink: checks each accepted transaction, then stalls at random.
    initial
    begin : message_sink
        int        stall_left;
        midi_msg_t got;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = {status, data_first, data_second, has_second, last};
                sb.check_message(got);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Watchdog: far beyond the slowest legal run (24 messages per event,
    // each behind the longest random sink stall, plus sender gaps).
    initial
    begin
        #30_000_000;
        $display("[midi_note_event_generator_top] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int               counted;
        int               r;
        logic [CMD_W-1:0] cmd;
        int               trk;
        bit               m;
        logic [15:0]      v;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // ---- directed, part one: highest channel, hold forever ----
        write_registers(4'd15, 8'd0, 8'd255);
        ev(CMD_START, 0, 127, 1'b0, 16'h0000);
        ev(CMD_START, 0, 0, 1'b0, 16'h0000);
        ev(CMD_CHORD, 0, 0, 1'b0, 16'h0C04);     // root 0: adds 4 and 12
        ev(CMD_TICK, 0, 0, 1'b0, 16'h0000);      // pending note-ons
        ev(CMD_TICK, 0, 0, 1'b0, 16'h0000);      // no countdown
        ev(CMD_VELOCITY, 0, 0, 1'b0, 16'hFFFF);
        ev(CMD_VOLUME, 0, 0, 1'b0, 16'hFFFF);
        ev(CMD_CC, 0, 0, 1'b0, 16'hFFFF);
        ev(CMD_PROGRAM, 0, 0, 1'b0, 16'h0000);
        ev(CMD_STOP, 0, 0, 1'b0, 16'h0000);
        // muted track: start only records root, later commands are dropped
        ev(CMD_START, 3, 5, 1'b1, 16'h0000);
        ev(CMD_STOP, 3, 0, 1'b0, 16'h0000);
        ev(CMD_VOLUME, 3, 0, 1'b0, 16'h1234);
        ev(CMD_TICK, 3, 0, 1'b0, 16'h0000);      // unmutes
        ev(4'hF, 0, 0, 1'b0, 16'hFFFF);          // unknown command
        settle();

        // ---- directed, part two: channel 0, length 1, volume 0 ----
        write_registers(4'd0, 8'd1, 8'd0);
        ev(CMD_START, 1, 60, 1'b0, 16'h0000);
        ev(CMD_RETRIG, 1, 0, 1'b0, 16'h0101);
        ev(CMD_TICK, 1, 0, 1'b0, 16'h0000);      // note-on then retrigger
        ev(CMD_RETRIG, 1, 0, 1'b0, 16'hFF00);    // off, countdown kept
        ev(CMD_TICK, 1, 0, 1'b0, 16'h0000);      // countdown ends: stop
        // fill track 2; last chord wraps past 127 and overflows the list
        ev(CMD_START, 2, 120, 1'b0, 16'h0000);
        ev(CMD_CHORD, 2, 0, 1'b0, 16'h0302);
        ev(CMD_CHORD, 2, 0, 1'b0, 16'h0504);
        ev(CMD_CHORD, 2, 0, 1'b0, 16'h0706);
        ev(CMD_CHORD, 2, 0, 1'b0, 16'h0908);
        ev(CMD_START, 2, 1, 1'b0, 16'h0000);     // full list ignores insert
        ev(CMD_TICK, 2, 0, 1'b1, 16'h0000);      // mute raised: stop and mute
        settle();

        // ---- random phases ----
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       write_registers(4'd15, 8'd255, 8'd255);
                1:       write_registers(4'd0, 8'd0, 8'd0);
                default: write_registers(4'($urandom), 8'($urandom_range(1, 6)),
                                         8'($urandom));
            endcase
            no_idle = (p == 3);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)      cmd = CMD_START;
                else if (r < 48) cmd = CMD_TICK;
                else if (r < 60) cmd = CMD_CHORD;
                else if (r < 68) cmd = CMD_STOP;
                else if (r < 75) cmd = CMD_RETRIG;
                else if (r < 80) cmd = CMD_VELOCITY;
                else if (r < 85) cmd = CMD_VOLUME;
                else if (r < 90) cmd = CMD_CC;
                else if (r < 95) cmd = CMD_PROGRAM;
                else             cmd = CMD_W'($urandom_range(9, 15));
                // concentrate on two tracks so their lists fill up
                trk = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(0, 7);
                m   = ($urandom_range(0, 9) == 0);
                v   = 16'($urandom);
                if (cmd == CMD_RETRIG && $urandom_range(0, 3) != 0)
                    v[7:0] = 8'($urandom_range(0, 4));
                if (cmd == CMD_CHORD && $urandom_range(0, 3) == 0)
                    v[15:8] = 8'($urandom_range(0, 12));
                ev(cmd, trk, $urandom_range(0, 127), m, v);
                counted++;
                if ($urandom_range(0, 79) == 0)
                    drain();
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("[midi_note_event_generator_top] OK");
        else
            $display("[midi_note_event_generator_top] ERROR");
        $finish;
    end

endmodule
